// ===== sv/bpa_pkg.sv =====
// Shared types, constants and helper functions for the bitmap pixel to ARGB converter.
// No dependencies; every other file imports this package.
package bpa_pkg;

    localparam int WORD_W      = 32;
    localparam int CHAN_W      = 8;
    localparam int SH_W        = 5;
    localparam int NUM_W       = WORD_W + CHAN_W;
    localparam int PREP_STAGES = 3;
    localparam int DIV_STAGES  = CHAN_W;
    localparam int LATENCY     = PREP_STAGES + DIV_STAGES;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CHAN_W-1:0] OPAQUE_ALPHA = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_IS_32BIT         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_BITFIELDS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ALPHA_VALID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_BITS         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_BITS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_BITS        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_BITS       = 3'd6;

    localparam logic [WORD_W-1:0] RED_BITS_RST   = 32'h00FF_0000;
    localparam logic [WORD_W-1:0] GREEN_BITS_RST = 32'h0000_FF00;
    localparam logic [WORD_W-1:0] BLUE_BITS_RST  = 32'h0000_00FF;
    localparam logic [WORD_W-1:0] ALPHA_BITS_RST = 32'h0000_0000;

    typedef struct packed {
        logic              is_32bit;
        logic              use_bitfields;
        logic              source_alpha_valid;
        logic [WORD_W-1:0] red_bits;
        logic [WORD_W-1:0] green_bits;
        logic [WORD_W-1:0] blue_bits;
        logic [WORD_W-1:0] alpha_bits;
    } bpa_cfg_t;

    typedef struct packed {
        logic              sel_bitfields;
        logic [WORD_W-1:0] plain;
    } bpa_side_t;

    // Converts a one-hot word into the index of its set bit.
    function automatic logic [SH_W-1:0] onehot_to_idx(input logic [WORD_W-1:0] oh);
        logic [SH_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (oh[i])
            begin
                idx = idx | SH_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== sv/bpa_cfg_regs.sv =====
// Configuration register bank of the bitmap pixel to ARGB converter.
// Depends on bpa_pkg for the register indexes, reset values and the config struct.
module bpa_cfg_regs
    import bpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata,
    output bpa_cfg_t             cfg
);

    bpa_cfg_t cfg_reg;
    bpa_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IS_32BIT:        cfg_next.is_32bit           = cfg_wdata[0];
                REG_USE_BITFIELDS:   cfg_next.use_bitfields      = cfg_wdata[0];
                REG_SRC_ALPHA_VALID: cfg_next.source_alpha_valid = cfg_wdata[0];
                REG_RED_BITS:        cfg_next.red_bits           = cfg_wdata;
                REG_GREEN_BITS:      cfg_next.green_bits         = cfg_wdata;
                REG_BLUE_BITS:       cfg_next.blue_bits          = cfg_wdata;
                REG_ALPHA_BITS:      cfg_next.alpha_bits         = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.is_32bit           <= 1'b1;
            cfg_reg.use_bitfields      <= 1'b0;
            cfg_reg.source_alpha_valid <= 1'b0;
            cfg_reg.red_bits           <= RED_BITS_RST;
            cfg_reg.green_bits         <= GREEN_BITS_RST;
            cfg_reg.blue_bits          <= BLUE_BITS_RST;
            cfg_reg.alpha_bits         <= ALPHA_BITS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/bpa_div_step.sv =====
// One registered restoring-division step that resolves a single quotient bit.
// Depends on bpa_pkg for the numerator and channel widths.
module bpa_div_step
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [2:0]        bit_idx,
    input  logic [NUM_W-1:0]  rem_in,
    input  logic [WORD_W-1:0] top_in,
    input  logic [CHAN_W-1:0] quot_in,
    input  logic              zero_in,
    output logic [NUM_W-1:0]  rem_out,
    output logic [WORD_W-1:0] top_out,
    output logic [CHAN_W-1:0] quot_out,
    output logic              zero_out
);

    logic [NUM_W-1:0]  divisor;
    logic [NUM_W:0]    diff;
    logic              fits;
    logic [NUM_W-1:0]  rem_next;
    logic [CHAN_W-1:0] quot_next;
    logic [NUM_W-1:0]  rem_reg;
    logic [WORD_W-1:0] top_reg;
    logic [CHAN_W-1:0] quot_reg;
    logic              zero_reg;

    always_comb
    begin
        divisor   = {{(NUM_W-WORD_W){1'b0}}, top_in} << bit_idx;
        diff      = {1'b0, rem_in} - {1'b0, divisor};
        fits      = !diff[NUM_W];
        rem_next  = fits ? diff[NUM_W-1:0] : rem_in;
        quot_next = quot_in;
        if (fits)
        begin
            quot_next[bit_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            top_reg  <= top_in;
            quot_reg <= quot_next;
            zero_reg <= zero_in;
        end
    end

    assign rem_out  = rem_reg;
    assign top_out  = top_reg;
    assign quot_out = quot_reg;
    assign zero_out = zero_reg;

endmodule

// ===== sv/bpa_chan_scale.sv =====
// Pipeline for one color channel: mask isolation, normalizing shift, rounding numerator
// and an eight-step division. Depends on bpa_pkg and bpa_div_step.
module bpa_chan_scale
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [WORD_W-1:0] pixel,
    input  logic [WORD_W-1:0] mask,
    output logic [CHAN_W-1:0] value,
    output logic              mask_zero
);

    logic [WORD_W-1:0] low_bit;
    logic [WORD_W-1:0] s1_masked_reg;
    logic [WORD_W-1:0] s1_mask_reg;
    logic [SH_W-1:0]   s1_sh_reg;
    logic              s1_zero_reg;
    logic [WORD_W-1:0] s2_val_reg;
    logic [WORD_W-1:0] s2_top_reg;
    logic              s2_zero_reg;
    logic [NUM_W-1:0]  num_next;
    logic [NUM_W-1:0]  s3_num_reg;
    logic [WORD_W-1:0] s3_top_reg;
    logic              s3_zero_reg;

    logic [NUM_W-1:0]  stage_rem  [DIV_STAGES+1];
    logic [WORD_W-1:0] stage_top  [DIV_STAGES+1];
    logic [CHAN_W-1:0] stage_quot [DIV_STAGES+1];
    logic              stage_zero [DIV_STAGES+1];

    assign low_bit = mask & (~mask + 32'd1);

    assign num_next = {s2_val_reg, {CHAN_W{1'b0}}}
                    - {{CHAN_W{1'b0}}, s2_val_reg}
                    + {{(CHAN_W+1){1'b0}}, s2_top_reg[WORD_W-1:1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_masked_reg <= pixel & mask;
            s1_mask_reg   <= mask;
            s1_sh_reg     <= onehot_to_idx(low_bit);
            s1_zero_reg   <= (mask == '0);
            s2_val_reg    <= s1_masked_reg >> s1_sh_reg;
            s2_top_reg    <= s1_mask_reg >> s1_sh_reg;
            s2_zero_reg   <= s1_zero_reg;
            s3_num_reg    <= num_next;
            s3_top_reg    <= s2_top_reg;
            s3_zero_reg   <= s2_zero_reg;
        end
    end

    assign stage_rem[0]  = s3_num_reg;
    assign stage_top[0]  = s3_top_reg;
    assign stage_quot[0] = '0;
    assign stage_zero[0] = s3_zero_reg;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        bpa_div_step u_step (
            .clk      (clk),
            .en       (en),
            .bit_idx  (3'(DIV_STAGES - 1 - k)),
            .rem_in   (stage_rem[k]),
            .top_in   (stage_top[k]),
            .quot_in  (stage_quot[k]),
            .zero_in  (stage_zero[k]),
            .rem_out  (stage_rem[k+1]),
            .top_out  (stage_top[k+1]),
            .quot_out (stage_quot[k+1]),
            .zero_out (stage_zero[k+1])
        );
    end

    assign value     = stage_zero[DIV_STAGES] ? '0 : stage_quot[DIV_STAGES];
    assign mask_zero = stage_zero[DIV_STAGES];

endmodule

// ===== sv/bmp_pixel_to_argb_converter.sv =====
// Top level of the bitmap pixel to ARGB8888 converter.
// Depends on bpa_pkg, bpa_cfg_regs and bpa_chan_scale.
//
// A raw pixel request enters on pixel_valid/pixel_ready with pixel_word and leaves as
// an ARGB8888 word on argb_valid/argb_ready with argb. Each pixel is independent.
// The block is a pipeline of 11 register stages: three for mask isolation, shifting
// and the rounding numerator, and eight division steps, one per bit of the channel.
// A request accepted on pixel_valid/pixel_ready moves through the stages in order
// and is then offered on argb until argb_ready takes it. One request is accepted
// every cycle unless the output stalls, so throughput is one pixel per clock.
// The configuration port takes a write at any edge with cfg_wr_en high; it should
// be used only while no request is in flight.
// Reset empties the pipeline and returns the registers to 32-bit plain mode with
// the standard red, green and blue masks and no alpha.
// When the receiver holds argb_ready low with a result waiting, every stage holds
// and pixel_ready drops in the same cycle; nothing is lost or repeated.
module bmp_pixel_to_argb_converter
    import bpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  logic [WORD_W-1:0]    pixel_word,
    output logic                 argb_valid,
    input  logic                 argb_ready,
    output logic [WORD_W-1:0]    argb,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata
);

    bpa_cfg_t          cfg;
    logic              en;
    logic [LATENCY-1:0] valid_reg;
    bpa_side_t         side_reg [LATENCY];
    bpa_side_t         side_next;
    logic [CHAN_W-1:0] alpha_val;
    logic [CHAN_W-1:0] red_val;
    logic [CHAN_W-1:0] green_val;
    logic [CHAN_W-1:0] blue_val;
    logic              alpha_zero;
    logic              red_zero;
    logic              green_zero;
    logic              blue_zero;
    logic [CHAN_W-1:0] alpha_out;
    logic [CHAN_W-1:0] plain_alpha;

    bpa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign en          = !valid_reg[LATENCY-1] || argb_ready;
    assign pixel_ready = en;

    always_comb
    begin
        plain_alpha = (cfg.is_32bit && cfg.source_alpha_valid) ? pixel_word[31:24]
                                                                : OPAQUE_ALPHA;
        side_next.sel_bitfields = cfg.is_32bit && cfg.use_bitfields;
        side_next.plain         = {plain_alpha, pixel_word[23:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], pixel_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < LATENCY; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    bpa_chan_scale u_alpha (
        .clk       (clk),
        .en        (en),
        .pixel     (pixel_word),
        .mask      (cfg.alpha_bits),
        .value     (alpha_val),
        .mask_zero (alpha_zero)
    );

    bpa_chan_scale u_red (
        .clk       (clk),
        .en        (en),
        .pixel     (pixel_word),
        .mask      (cfg.red_bits),
        .value     (red_val),
        .mask_zero (red_zero)
    );

    bpa_chan_scale u_green (
        .clk       (clk),
        .en        (en),
        .pixel     (pixel_word),
        .mask      (cfg.green_bits),
        .value     (green_val),
        .mask_zero (green_zero)
    );

    bpa_chan_scale u_blue (
        .clk       (clk),
        .en        (en),
        .pixel     (pixel_word),
        .mask      (cfg.blue_bits),
        .value     (blue_val),
        .mask_zero (blue_zero)
    );

    // A zero color mask already yields zero; only alpha turns into opaque.
    always_comb
    begin
        alpha_out = alpha_zero ? OPAQUE_ALPHA : alpha_val;
        if (side_reg[LATENCY-1].sel_bitfields)
        begin
            argb = {alpha_out,
                    red_zero   ? {CHAN_W{1'b0}} : red_val,
                    green_zero ? {CHAN_W{1'b0}} : green_val,
                    blue_zero  ? {CHAN_W{1'b0}} : blue_val};
        end
        else
        begin
            argb = side_reg[LATENCY-1].plain;
        end
    end

    assign argb_valid = valid_reg[LATENCY-1];

endmodule

// ===== sv/bpa_checker.sv =====
// Port-level checker for the bitmap pixel to ARGB converter and its bind statement.
// Depends on bpa_pkg for the port widths.
module bpa_checker
    import bpa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              pixel_ready,
    input logic              argb_valid,
    input logic              argb_ready,
    input logic [WORD_W-1:0] argb
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        argb_valid && !argb_ready |=> argb_valid)
        else $error("A stalled result was withdrawn.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        argb_valid && !argb_ready |=> $stable(argb))
        else $error("A stalled result changed.");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !argb_valid)
        else $error("A result was offered during reset.");

    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        !argb_valid || argb_ready |-> pixel_ready)
        else $error("A request was refused while the output was free.");

endmodule

bind bmp_pixel_to_argb_converter bpa_checker u_bpa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_ready (pixel_ready),
    .argb_valid  (argb_valid),
    .argb_ready  (argb_ready),
    .argb        (argb)
);

// ===== verif/bmp_pixel_to_argb_converter_tb.sv =====
// Testbench for bmp_pixel_to_argb_converter: predicts each ARGB word from the pixel and the
// programmed mode and masks, and compares results in order under random idling and stalls.
// Depends on bpa_pkg and the converter RTL.
`timescale 1ns / 1ps

module bmp_pixel_to_argb_converter_tb
    import bpa_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int TX_STREAM = 0;
    localparam int TX_BURSTY = 1;

    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_STRETCH  = 3;

    logic                 clk;
    logic                 rst_n;
    logic                 pixel_valid;
    logic                 pixel_ready;
    logic [WORD_W-1:0]    pixel_word;
    logic                 argb_valid;
    logic                 argb_ready;
    logic [WORD_W-1:0]    argb;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_wdata;

    bpa_cfg_t          cfg_shadow;
    logic [WORD_W-1:0] pending_argb_q[$];
    int                mismatch_count;
    int                cycle_count;
    int                tx_mode;
    int                rx_mode;
    int                burst_left;
    int                long_hold_cycles;

    bmp_pixel_to_argb_converter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_word  (pixel_word),
        .argb_valid  (argb_valid),
        .argb_ready  (argb_ready),
        .argb        (argb),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [CHAN_W-1:0] scale_to_byte(input logic [WORD_W-1:0] px,
                                                        input logic [WORD_W-1:0] mask);
        int unsigned       sh;
        logic [WORD_W-1:0] field;
        logic [WORD_W-1:0] top;
        logic [63:0]       num;
        if (mask == '0)
        begin
            return '0;
        end
        sh = 0;
        while (sh < WORD_W - 1 && mask[sh] == 1'b0)
        begin
            sh++;
        end
        field = (px & mask) >> sh;
        top   = mask >> sh;
        num   = 64'(field) * 64'd255 + 64'(top >> 1);
        return CHAN_W'(num / 64'(top));
    endfunction

    function automatic logic [WORD_W-1:0] argb_of_pixel(input logic [WORD_W-1:0] px);
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        a = OPAQUE_ALPHA;
        if (cfg_shadow.is_32bit && cfg_shadow.use_bitfields)
        begin
            r = scale_to_byte(px, cfg_shadow.red_bits);
            g = scale_to_byte(px, cfg_shadow.green_bits);
            b = scale_to_byte(px, cfg_shadow.blue_bits);
            if (cfg_shadow.alpha_bits != '0)
            begin
                a = scale_to_byte(px, cfg_shadow.alpha_bits);
            end
        end
        else
        begin
            b = px[7:0];
            g = px[15:8];
            r = px[23:16];
            if (cfg_shadow.is_32bit && cfg_shadow.source_alpha_valid)
            begin
                a = px[31:24];
            end
        end
        return {a, r, g, b};
    endfunction

    function automatic bpa_cfg_t make_cfg(input logic is32, input logic bf, input logic sav,
                                          input logic [WORD_W-1:0] r, input logic [WORD_W-1:0] g,
                                          input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] a);
        bpa_cfg_t c;
        c.is_32bit           = is32;
        c.use_bitfields      = bf;
        c.source_alpha_valid = sav;
        c.red_bits           = r;
        c.green_bits         = g;
        c.blue_bits          = b;
        c.alpha_bits         = a;
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] rand_mask();
        int unsigned w;
        int unsigned lo;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
            3: return $urandom();
            default:
            begin
                w  = $urandom_range(1, WORD_W);
                lo = $urandom_range(0, WORD_W - w);
                return WORD_W'(((64'd1 << w) - 64'd1) << lo);
            end
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
            3: return ~(WORD_W'(1) << $urandom_range(0, WORD_W - 1));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] flag_word(input logic flag);
        return (WORD_W'($urandom()) & ~WORD_W'(1)) | WORD_W'(flag);
    endfunction

    task automatic send_pixel(input logic [WORD_W-1:0] word);
        int gap;
        if (tx_mode == TX_BURSTY && burst_left <= 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                pixel_valid <= 1'b0;
                pixel_word  <= $urandom();
                @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        pixel_valid <= 1'b1;
        pixel_word  <= word;
        @(posedge clk);
        while (!pixel_ready)
        begin
            @(posedge clk);
        end
        pending_argb_q.push_back(argb_of_pixel(word));
        burst_left--;
    endtask

    task automatic wait_idle();
        pixel_valid <= 1'b0;
        while (pending_argb_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(input bpa_cfg_t c);
        wait_idle();
        cfg_wr_en <= 1'b1;
        put_reg(REG_IS_32BIT, flag_word(c.is_32bit));
        put_reg(REG_USE_BITFIELDS, flag_word(c.use_bitfields));
        put_reg(REG_SRC_ALPHA_VALID, flag_word(c.source_alpha_valid));
        put_reg(REG_RED_BITS, c.red_bits);
        put_reg(REG_GREEN_BITS, c.green_bits);
        put_reg(REG_BLUE_BITS, c.blue_bits);
        put_reg(REG_ALPHA_BITS, c.alpha_bits);
        put_reg(REG_UNUSED, $urandom());
        cfg_wr_en <= 1'b0;
        cfg_shadow = c;
    endtask

    task automatic test_reset_defaults();
        tx_mode = TX_STREAM;
        rx_mode = RX_ALWAYS;
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h1234_5678);
    endtask

    task automatic test_plain_modes();
        program_regs(make_cfg(1'b0, 1'b1, 1'b1, '0, '0, '0, '1));
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hA5C3_0F81);
        program_regs(make_cfg(1'b1, 1'b0, 1'b1, '0, '0, '0, '0));
        send_pixel(32'h7F80_01FE);
        send_pixel(32'hFF00_FF00);
        program_regs(make_cfg(1'b1, 1'b0, 1'b0, '1, '1, '1, '1));
        send_pixel(32'h80FF_0000);
        send_pixel(32'h0000_0000);
    endtask

    task automatic test_bitfields_directed();
        program_regs(make_cfg(1'b1, 1'b1, 1'b1, 32'hF800, 32'h07E0, 32'h001F, 32'h0));
        send_pixel(32'h0000_FFFF);
        send_pixel(32'hFFFF_7BEF);
        program_regs(make_cfg(1'b1, 1'b1, 1'b0, 32'h7C00, 32'h03E0, 32'h001F, 32'h8000));
        send_pixel(32'h0000_8000);
        send_pixel(32'h0000_4210);
        program_regs(make_cfg(1'b1, 1'b1, 1'b1, '0, '0, '0, '0));
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        program_regs(make_cfg(1'b1, 1'b1, 1'b0, '1, '1, '1, '1));
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h7FFF_FFFF);
        program_regs(make_cfg(1'b1, 1'b1, 1'b0, 32'h8000_0000, 32'hFFFF_0000,
                              32'h0001_FFFE, 32'h0000_0001));
        send_pixel(32'h8000_0001);
        send_pixel(32'h7FFF_FFFE);
        program_regs(make_cfg(1'b1, 1'b1, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555,
                              32'h0F0F_0F0F, 32'hF00F_0000));
        send_pixel(32'hAAAA_AAAA);
        send_pixel(32'h5555_5555);
    endtask

    task automatic test_random_phases();
        bpa_cfg_t c;
        for (int ph = 0; ph < 9; ph++)
        begin
            c = make_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)),
                         rand_mask(), rand_mask(), rand_mask(), rand_mask());
            case (ph % 4)
                0: c.is_32bit = 1'b0;
                1:
                begin
                    c.is_32bit      = 1'b1;
                    c.use_bitfields = 1'b0;
                end
                default:
                begin
                    c.is_32bit      = 1'b1;
                    c.use_bitfields = 1'b1;
                end
            endcase
            program_regs(c);
            tx_mode = $urandom_range(TX_STREAM, TX_BURSTY);
            rx_mode = $urandom_range(RX_ALWAYS, RX_STRETCH);
            repeat (170) send_pixel(rand_pixel());
        end
    endtask

    task automatic test_backpressure();
        program_regs(make_cfg(1'b1, 1'b1, 1'b0, rand_mask(), rand_mask(), rand_mask(),
                              rand_mask()));
        tx_mode = TX_STREAM;
        rx_mode = RX_ALWAYS;
        long_hold_cycles = 80;
        repeat (100) send_pixel(rand_pixel());
    endtask

    initial
    begin
        int rx_tick;
        argb_ready = 1'b0;
        rx_tick    = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            rx_tick++;
            if (long_hold_cycles > 0)
            begin
                long_hold_cycles--;
                argb_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_RANDOM:   argb_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: argb_ready <= ((rx_tick % 7) >= 3);
                    RX_STRETCH:
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            argb_ready <= ~argb_ready;
                        end
                    end
                    default:     argb_ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && argb_valid && argb_ready)
        begin
            if (pending_argb_q.size() == 0)
            begin
                $display("%0t: argb expected none actual %h", $time, argb);
                mismatch_count++;
            end
            else if (argb !== pending_argb_q[0])
            begin
                $display("%0t: argb expected %h actual %h", $time, pending_argb_q[0], argb);
                mismatch_count++;
                void'(pending_argb_q.pop_front());
            end
            else
            begin
                void'(pending_argb_q.pop_front());
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        pixel_valid      = 1'b0;
        pixel_word       = '0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        mismatch_count   = 0;
        cycle_count      = 0;
        burst_left       = 0;
        long_hold_cycles = 0;
        tx_mode          = TX_STREAM;
        rx_mode          = RX_ALWAYS;
        cfg_shadow       = make_cfg(1'b1, 1'b0, 1'b0, RED_BITS_RST, GREEN_BITS_RST,
                                    BLUE_BITS_RST, ALPHA_BITS_RST);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_plain_modes();
        test_bitfields_directed();
        test_random_phases();
        test_backpressure();

        wait_idle();
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatch_count == 0 && pending_argb_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bpa_pkg.sv
sv/bpa_cfg_regs.sv
sv/bpa_div_step.sv
sv/bpa_chan_scale.sv
sv/bmp_pixel_to_argb_converter.sv
sv/bpa_checker.sv
verif/bmp_pixel_to_argb_converter_tb.sv
